>>> hw/rtl/ir_packet_receive_checker_top_macros.svh
// assertion macros for the ir packet receive checker
`ifndef IR_PACKET_RECEIVE_CHECKER_TOP_MACROS_SVH
`define IR_PACKET_RECEIVE_CHECKER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define IRPRC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("irprc same-cycle check failed");

// next-cycle implication, disabled during reset
`define IRPRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("irprc next-cycle check failed");

`endif

>>> hw/rtl/irprc_pkg.sv
// shared types and constants for the ir packet receive checker
package irprc_pkg;

    localparam int MAX_PACKET_BYTES = 136;

    localparam logic [7:0]  WHITEN_MASK = 8'hAA;
    localparam logic [15:0] SUM_SEED    = 16'h0002;

    localparam logic [31:0] SESS_KEY_RESET     = 32'hDEADBEEF;
    localparam logic [7:0]  EXPECTED_LEN_RESET = 8'd136;

    localparam int CFG_DATA_W = 32;

    typedef enum logic {
        REG_SESS_KEY     = 1'b0,
        REG_EXPECTED_LEN = 1'b1
    } cfg_addr_t;

    typedef enum logic {
        OP_BYTE    = 1'b0,
        OP_TIMEOUT = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TIMEOUT  = 3'd1,
        ST_SIZE     = 3'd2,
        ST_CHECKSUM = 3'd3,
        ST_SESSION  = 3'd4
    } status_t;

    typedef struct packed {
        opcode_t    opcode;
        logic [7:0] raw_byte;
        logic       last_byte;
    } irprc_item_t;

    typedef struct packed {
        logic [7:0] decoded_byte;
        logic [7:0] byte_count;
        logic       packet_done;
        status_t    status;
    } irprc_result_t;

endpackage

>>> hw/rtl/ir_packet_receive_checker_top.sv
// top level of the ir packet receive checker: handshake, config and result stage
//
// channel | dir | tdata (low bit up)                      | tuser  | tlast
// s_      | in  | raw_byte[7:0]                           | opcode | last_byte
// m_      | out | decoded_byte, byte_count, status, zeros  | none   | packet_done
//
// one word per cycle sustained while m_tready is high; a taken word reaches m_ through
// the input register (loads on accept) and the result register (loads on advance)
// reset clears the packet state, sum seed 2, session key 0xDEADBEEF, expected_len 136
// m_tready low holds a valid result; s_tready drops only when both stages are full
`include "ir_packet_receive_checker_top_macros.svh"

module ir_packet_receive_checker_top #(
    parameter int MAX_PACKET_BYTES = irprc_pkg::MAX_PACKET_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // raw_byte[7:0]
    input  logic        s_tuser,   // opcode[0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // decoded_byte[7:0], byte_count[15:8], status[18:16]
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [irprc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam logic [7:0] MaxBytes = 8'(MAX_PACKET_BYTES);

    logic [31:0]              sess_key_reg;
    logic [7:0]               expected_len_reg;
    irprc_pkg::irprc_item_t   item_reg;
    logic                     in_valid_reg;
    irprc_pkg::irprc_result_t result_reg;
    irprc_pkg::irprc_result_t result_next;
    logic                     out_valid_reg;
    logic                     advance;
    irprc_pkg::cfg_addr_t     cfg_sel;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;
    assign cfg_sel  = irprc_pkg::cfg_addr_t'(cfg_addr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sess_key_reg     <= irprc_pkg::SESS_KEY_RESET;
            expected_len_reg <= irprc_pkg::EXPECTED_LEN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_sel)
                irprc_pkg::REG_SESS_KEY:     sess_key_reg     <= cfg_wdata[31:0];
                irprc_pkg::REG_EXPECTED_LEN: expected_len_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.opcode    <= irprc_pkg::opcode_t'(s_tuser);
            item_reg.raw_byte  <= s_tdata;
            item_reg.last_byte <= s_tlast;
        end
    end

    irprc_core #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .item         (item_reg),
        .sess_key     (sess_key_reg),
        .expected_len (expected_len_reg),
        .result       (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = result_reg.packet_done;
    assign m_tdata  = {5'd0, 3'(result_reg.status), result_reg.byte_count,
                       result_reg.decoded_byte};

    `IRPRC_ASSERT_IMPLY(a_status_only_when_done, aclk, aresetn,
        m_tvalid && !m_tlast, result_reg.status == irprc_pkg::ST_OK)
    `IRPRC_ASSERT_IMPLY(a_timeout_zero_payload, aclk, aresetn,
        m_tvalid && result_reg.status == irprc_pkg::ST_TIMEOUT,
        m_tlast && result_reg.byte_count == 8'd0 && result_reg.decoded_byte == 8'd0)
    `IRPRC_ASSERT_IMPLY(a_count_saturates, aclk, aresetn,
        m_tvalid, result_reg.byte_count <= MaxBytes)
    `IRPRC_ASSERT_NEXT(a_input_stage_holds, aclk, aresetn,
        in_valid_reg && !advance, in_valid_reg && $stable(item_reg))

endmodule

>>> hw/rtl/irprc_core.sv
// packet state and per-word checksum, size and session checks
module irprc_core #(
    parameter int MAX_PACKET_BYTES = irprc_pkg::MAX_PACKET_BYTES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  irprc_pkg::irprc_item_t item,
    input  logic [31:0]            sess_key,
    input  logic [7:0]             expected_len,
    output irprc_pkg::irprc_result_t result
);

    localparam logic [7:0] MaxBytes = 8'(MAX_PACKET_BYTES);

    logic [7:0]  byte_counter_reg, byte_counter_next;
    logic [15:0] sum_reg, sum_next;
    logic [15:0] rx_csum_reg, rx_csum_next;
    logic        session_ok_reg, session_ok_next;
    logic        overflow_reg, overflow_next;

    logic [7:0]  decoded;
    logic [7:0]  pos;
    logic        accepting;
    logic [7:0]  term_byte;
    logic [15:0] term;
    logic [16:0] raw_sum;
    logic [15:0] folded_sum;
    logic [7:0]  want;
    logic        match;
    logic        size_bad;
    logic        clear;
    logic [15:0] acc_sum;
    logic [15:0] acc_csum;
    logic        acc_session;
    logic        acc_overflow;
    logic [7:0]  acc_count;

    assign decoded   = item.raw_byte ^ irprc_pkg::WHITEN_MASK;
    assign pos       = byte_counter_reg;
    assign accepting = (pos < MaxBytes);

    // checksum bytes add as zero, even offsets are the high byte
    assign term_byte  = (pos == 8'd2 || pos == 8'd3) ? 8'd0 : decoded;
    assign term       = pos[0] ? {8'd0, term_byte} : {term_byte, 8'd0};
    assign raw_sum    = {1'b0, sum_reg} + {1'b0, term};
    assign folded_sum = raw_sum[15:0] + {15'd0, raw_sum[16]};

    always_comb begin
        unique case (pos[1:0])
            2'd0:    want = sess_key[31:24];
            2'd1:    want = sess_key[23:16];
            2'd2:    want = sess_key[15:8];
            default: want = sess_key[7:0];
        endcase
    end

    assign match = (want == decoded);

    always_comb begin
        acc_sum      = sum_reg;
        acc_csum     = rx_csum_reg;
        acc_session  = session_ok_reg;
        acc_overflow = overflow_reg;
        acc_count    = byte_counter_reg;
        if (accepting) begin
            acc_sum   = folded_sum;
            acc_count = byte_counter_reg + 8'd1;
            if (pos == 8'd2) begin
                acc_csum = {rx_csum_reg[15:8], decoded};
            end else if (pos == 8'd3) begin
                acc_csum = {decoded, rx_csum_reg[7:0]};
            end else if (pos >= 8'd4 && pos <= 8'd7) begin
                acc_session = (pos == 8'd4) ? match : (session_ok_reg && match);
            end
        end else begin
            acc_overflow = 1'b1;
        end
    end

    assign size_bad = acc_overflow ||
                      (expected_len < MaxBytes && acc_count != expected_len);

    always_comb begin
        result = '0;
        if (item.opcode == irprc_pkg::OP_TIMEOUT) begin
            result.decoded_byte = 8'd0;
            result.byte_count   = 8'd0;
            result.packet_done  = 1'b1;
            result.status       = irprc_pkg::ST_TIMEOUT;
        end else begin
            result.decoded_byte = decoded;
            result.byte_count   = acc_count;
            result.packet_done  = item.last_byte;
            result.status       = irprc_pkg::ST_OK;
            if (item.last_byte) begin
                if (size_bad) begin
                    result.status = irprc_pkg::ST_SIZE;
                end else if (acc_sum != acc_csum) begin
                    result.status = irprc_pkg::ST_CHECKSUM;
                end else if (!(acc_session && acc_count >= 8'd8)) begin
                    result.status = irprc_pkg::ST_SESSION;
                end
            end
        end
    end

    assign clear = (item.opcode == irprc_pkg::OP_TIMEOUT) || item.last_byte;

    always_comb begin
        byte_counter_next = acc_count;
        sum_next          = acc_sum;
        rx_csum_next      = acc_csum;
        session_ok_next   = acc_session;
        overflow_next     = acc_overflow;
        if (clear) begin
            byte_counter_next = 8'd0;
            sum_next          = irprc_pkg::SUM_SEED;
            rx_csum_next      = 16'd0;
            session_ok_next   = 1'b0;
            overflow_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_counter_reg <= 8'd0;
            sum_reg          <= irprc_pkg::SUM_SEED;
            rx_csum_reg      <= 16'd0;
            session_ok_reg   <= 1'b0;
            overflow_reg     <= 1'b0;
        end else if (step) begin
            byte_counter_reg <= byte_counter_next;
            sum_reg          <= sum_next;
            rx_csum_reg      <= rx_csum_next;
            session_ok_reg   <= session_ok_next;
            overflow_reg     <= overflow_next;
        end
    end

endmodule
